// ----- rtl/bavg_pkg.sv -----
package bavg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RUN_W      = 18;
    localparam int SUM_W      = 20;
    localparam int IDX_W      = 7;
    localparam int CFG_W      = 10;
    localparam int TILE       = 4;
    localparam int TILE_SHIFT = 2;
    localparam int MEAN_SHIFT = 4;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int OUT_W      = 32;

    localparam logic [TILE_SHIFT-1:0] TILE_FIRST = '0;
    localparam logic [TILE_SHIFT-1:0] TILE_LAST  = TILE_SHIFT'(TILE - 1);

    localparam logic [CFG_W-1:0] RES_RESET = CFG_W'(512);

    // register index as decoded from paddr[2]
    localparam logic REG_RES_IN_USE = 1'b0;

    typedef struct packed {
        logic [TILE_SHIFT-1:0] col_lo;
        logic [TILE_SHIFT-1:0] row_lo;
        logic [IDX_W-1:0]      tile_row;
        logic [IDX_W-1:0]      tile_col;
        logic                  frame_end;
    } pos_info_t;

endpackage

// ----- rtl/box_average_downsample_4x4_core.sv -----
// The sample that completes a tile passes the a stage register, then the output register.
// Throughput: one sample per cycle unless a result waits on m_tready; the column-sum memory
//   is read on accept, written from the a stage, so back-to-back samples never wait on it.
// Reset (aresetn low, synchronous): position and running sum clear, res_in_use
//   returns to 512; column sums are written before they are read, so need no clear.
module box_average_downsample_4x4_core #(
    parameter int MAX_SIDE = 512
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB-style configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bavg_pkg::ADDR_W-1:0]     paddr,
    input  logic [bavg_pkg::DATA_W-1:0]     pwdata,
    output logic [bavg_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    // samples
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bavg_pkg::SAMPLE_W-1:0]   s_tdata,  // [15:0] height_sample
    // tile results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bavg_pkg::OUT_W-1:0]      m_tdata,  // [15:0] tile_mean, [22:16] tile_row,
                                                      // [29:23] tile_col, [31:30] zero
    output logic                            m_tlast   // frame_end
);

    localparam int CNT_W    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int TC_W     = (CNT_W > bavg_pkg::TILE_SHIFT) ?
                              CNT_W - bavg_pkg::TILE_SHIFT : 1;
    localparam int CMP_W    = (SIDE_W > bavg_pkg::CFG_W) ? SIDE_W : bavg_pkg::CFG_W;
    localparam int SIDE_RST = (MAX_SIDE < 512) ? MAX_SIDE : 512;

    logic [bavg_pkg::CFG_W-1:0] res_reg;
    logic [SIDE_W-1:0]          side_reg, side_next;
    logic [CMP_W-1:0]           side_rnd;
    logic                       cfg_wr, restart;
    bavg_pkg::pos_info_t        info;
    logic [TC_W-1:0]            tc;

    always_comb begin
        cfg_wr  = psel && penable && pwrite;
        restart = cfg_wr && paddr[2] == bavg_pkg::REG_RES_IN_USE;

        // drop the low bits, then clamp to the supported range
        side_rnd = CMP_W'({pwdata[bavg_pkg::CFG_W-1:bavg_pkg::TILE_SHIFT],
                           bavg_pkg::TILE_FIRST});
        if (side_rnd < CMP_W'(bavg_pkg::TILE)) begin
            side_next = SIDE_W'(bavg_pkg::TILE);
        end else if (side_rnd > CMP_W'(MAX_SIDE)) begin
            side_next = SIDE_W'(MAX_SIDE);
        end else begin
            side_next = SIDE_W'(side_rnd);
        end

        prdata = (paddr[2] == bavg_pkg::REG_RES_IN_USE) ?
                 bavg_pkg::DATA_W'(res_reg) : '0;
    end

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg  <= bavg_pkg::RES_RESET;
            side_reg <= SIDE_W'(SIDE_RST);
        end else if (restart) begin
            res_reg  <= pwdata[bavg_pkg::CFG_W-1:0];
            side_reg <= side_next;
        end
    end

    bavg_pos #(
        .MAX_SIDE (MAX_SIDE)
    ) u_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (restart),
        .advance (s_tvalid && s_tready),
        .side    (side_reg),
        .info    (info),
        .tc      (tc)
    );

    bavg_acc #(
        .MAX_SIDE (MAX_SIDE)
    ) u_acc (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (restart),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .height_sample (s_tdata),
        .info          (info),
        .tc            (tc),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

// ----- rtl/bavg_pos.sv -----
module bavg_pos #(
    parameter int  MAX_SIDE = 512,
    localparam int CNT_W    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1),
    localparam int TC_W     = (CNT_W > bavg_pkg::TILE_SHIFT) ?
                              CNT_W - bavg_pkg::TILE_SHIFT : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                restart,
    input  logic                advance,
    input  logic [SIDE_W-1:0]   side,
    output bavg_pkg::pos_info_t info,
    output logic [TC_W-1:0]     tc
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_eff, row_eff;
    logic             col_last, row_last;

    always_comb begin
        // wrap a stale position back into the frame
        col_eff  = (SIDE_W'(col_reg) >= side) ? '0 : col_reg;
        row_eff  = (SIDE_W'(row_reg) >= side) ? '0 : row_reg;
        col_last = (SIDE_W'(col_eff) == side - SIDE_W'(1));
        row_last = (SIDE_W'(row_eff) == side - SIDE_W'(1));

        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : row_eff + CNT_W'(1);
        end else begin
            col_next = col_eff + CNT_W'(1);
            row_next = row_eff;
        end

        info.col_lo    = col_eff[bavg_pkg::TILE_SHIFT-1:0];
        info.row_lo    = row_eff[bavg_pkg::TILE_SHIFT-1:0];
        info.tile_col  = bavg_pkg::IDX_W'(col_eff >> bavg_pkg::TILE_SHIFT);
        info.tile_row  = bavg_pkg::IDX_W'(row_eff >> bavg_pkg::TILE_SHIFT);
        info.frame_end = col_last && row_last;
        tc             = TC_W'(col_eff >> bavg_pkg::TILE_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    a_wrap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && info.frame_end |=> col_reg == '0 && row_reg == '0)
        else $error("position did not wrap after last sample");

endmodule

// ----- rtl/bavg_acc.sv -----
module bavg_acc #(
    parameter int  MAX_SIDE = 512,
    localparam int CNT_W    = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1,
    localparam int TC_W     = (CNT_W > bavg_pkg::TILE_SHIFT) ?
                              CNT_W - bavg_pkg::TILE_SHIFT : 1,
    localparam int TC_N     = MAX_SIDE / bavg_pkg::TILE
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           restart,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bavg_pkg::SAMPLE_W-1:0]  height_sample,
    input  bavg_pkg::pos_info_t            info,
    input  logic [TC_W-1:0]                tc,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bavg_pkg::OUT_W-1:0]     m_tdata,
    output logic                           m_tlast
);

    logic [bavg_pkg::SUM_W-1:0] col_sum_mem [TC_N];

    logic [bavg_pkg::RUN_W-1:0] run_sum_reg, run_sum_next;
    logic [bavg_pkg::SUM_W-1:0] rd_data_reg;

    logic                       a_vld_reg;
    logic [bavg_pkg::RUN_W-1:0] a_run_reg;
    bavg_pkg::pos_info_t        a_info_reg;
    logic [TC_W-1:0]            a_tc_reg;

    logic                         m_vld_reg;
    logic [bavg_pkg::SAMPLE_W-1:0] mean_reg;
    logic [bavg_pkg::IDX_W-1:0]    row_reg, col_reg;
    logic                         last_reg;

    logic                       s_fire, a_fire, a_wr, a_emit, out_free;
    logic [bavg_pkg::SUM_W-1:0] total;

    always_comb begin
        a_wr     = a_info_reg.col_lo == bavg_pkg::TILE_LAST;
        a_emit   = a_wr && a_info_reg.row_lo == bavg_pkg::TILE_LAST;
        out_free = !m_vld_reg || m_tready;
        a_fire   = a_vld_reg && (!a_emit || out_free);
        s_tready = !a_vld_reg || a_fire;
        s_fire   = s_tvalid && s_tready;

        if (info.col_lo == bavg_pkg::TILE_FIRST) begin
            run_sum_next = bavg_pkg::RUN_W'(height_sample);
        end else begin
            run_sum_next = run_sum_reg + bavg_pkg::RUN_W'(height_sample);
        end

        // top row of a tile starts the column sum afresh
        if (a_info_reg.row_lo == bavg_pkg::TILE_FIRST) begin
            total = bavg_pkg::SUM_W'(a_run_reg);
        end else begin
            total = rd_data_reg + bavg_pkg::SUM_W'(a_run_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_data_reg <= col_sum_mem[tc];
        end
        if (a_fire && a_wr) begin
            col_sum_mem[a_tc_reg] <= total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sum_reg <= '0;
            a_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            if (restart) begin
                run_sum_reg <= '0;
            end else if (s_fire) begin
                run_sum_reg <= run_sum_next;
            end

            if (s_fire) begin
                a_vld_reg <= 1'b1;
            end else if (a_fire) begin
                a_vld_reg <= 1'b0;
            end

            if (a_fire && a_emit) begin
                m_vld_reg <= 1'b1;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_run_reg  <= run_sum_next;
            a_info_reg <= info;
            a_tc_reg   <= tc;
        end
        if (a_fire && a_emit) begin
            mean_reg <= bavg_pkg::SAMPLE_W'(total >> bavg_pkg::MEAN_SHIFT);
            row_reg  <= a_info_reg.tile_row;
            col_reg  <= a_info_reg.tile_col;
            last_reg <= a_info_reg.frame_end;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(bavg_pkg::OUT_W - bavg_pkg::SAMPLE_W - 2 * bavg_pkg::IDX_W){1'b0}},
                       col_reg, row_reg, mean_reg};

    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        a_vld_reg && a_emit && !out_free |=> a_vld_reg && $stable(a_info_reg))
        else $error("stalled tile request lost");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_vld_reg |-> s_tready)
        else $error("input stalled with empty stage");

    a_last_is_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_vld_reg && last_reg |-> row_reg == col_reg)
        else $error("frame end not on corner tile");

endmodule
